[hdl/mbe_pkg.sv]
// Shared types, constants and sizes for the escape-time pixel evaluator.
`timescale 1ns / 1ps
`default_nettype none
package mbe_pkg;

  // Image geometry; the pixel offset is taken from the integer half size
  localparam int IMG_WIDTH  = 1024;
  localparam int IMG_HEIGHT = 1024;
  localparam int HALF_W     = IMG_WIDTH / 2;
  localparam int HALF_H     = IMG_HEIGHT / 2;
  localparam int IMG_MAX    = (IMG_WIDTH > IMG_HEIGHT) ? IMG_WIDTH : IMG_HEIGHT;

  // Field widths
  localparam int PIX_W     = 10;
  localparam int ITER_W    = 16;
  localparam int CFG_W     = 44;
  localparam int VAL_W     = 64;
  localparam int FRAC_W    = 40;
  localparam int IN_DATA_W = 24;
  localparam int CFG_IDX_W = 3;

  // Signed pixel offset and mapping product widths
  localparam int DX_BASE = (PIX_W > $clog2(IMG_MAX)) ? PIX_W : $clog2(IMG_MAX);
  localparam int DX_W    = DX_BASE + 1;
  localparam int MAP_W   = DX_W + CFG_W + 1;

  // Bailout threshold is this multiple of the iteration limit
  localparam int BAIL_MUL = 50;
  localparam int BAIL_W   = ITER_W + 6;

  // Sequential multiplier: four 32x32 partial products
  localparam int HALF_VW    = VAL_W / 2;
  localparam int PROD_W     = 2 * VAL_W;
  localparam int MUL_PARTS  = 4;
  localparam int MUL_STEP_W = 3;

  // Saturation bounds, +-(2^63 - 1)
  localparam logic signed [VAL_W-1:0] SAT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] SAT_MIN = {1'b1, {(VAL_W-2){1'b0}}, 1'b1};

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_RE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_IM   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESULT_MODE = 3'd4;

  // Register reset values
  localparam logic [ITER_W-1:0] MAX_ITER_RST = 16'd256;
  localparam logic [CFG_W-1:0]  SCALE_RST    = 44'd3665038760;

  typedef struct packed {
    logic [ITER_W-1:0]       max_iter;
    logic [CFG_W-1:0]        scale;
    logic signed [CFG_W-1:0] offset_re;
    logic signed [CFG_W-1:0] offset_im;
    logic                    result_mode;
  } cfg_t;

  typedef struct packed {
    logic load_pix;
    logic map;
    logic init;
    logic update;
    logic mul_start;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic go;
    logic mul_done;
  } dp_status_t;

endpackage
`default_nettype wire

[hdl/mbe_mul.sv]
// Sequential signed 64x64 multiplier with truncating shift and saturation.
`timescale 1ns / 1ps
`default_nettype none
module mbe_mul (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 start,
  input  wire                                 dbl,
  input  wire logic signed [mbe_pkg::VAL_W-1:0] a,
  input  wire logic signed [mbe_pkg::VAL_W-1:0] b,
  output logic signed [mbe_pkg::VAL_W-1:0]      res,
  output logic                                done
);

  logic                               busy;
  logic [mbe_pkg::MUL_STEP_W-1:0]     step;
  logic [mbe_pkg::VAL_W-1:0]          xm;
  logic [mbe_pkg::VAL_W-1:0]          ym;
  logic                               neg;
  logic                               dbl_q;
  logic [mbe_pkg::VAL_W-1:0]          prod;
  logic [1:0]                         pw;
  logic [mbe_pkg::PROD_W-1:0]         acc;
  logic [mbe_pkg::HALF_VW-1:0]        x_half;
  logic [mbe_pkg::HALF_VW-1:0]        y_half;
  logic [mbe_pkg::PROD_W-1:0]         shifted;
  logic [mbe_pkg::VAL_W-1:0]          mag_res;
  logic                               in_mult;
  logic                               in_acc;
  logic                               last;

  function automatic logic [mbe_pkg::VAL_W-1:0] mag(input logic signed [mbe_pkg::VAL_W-1:0] v);
    return v[mbe_pkg::VAL_W-1] ? mbe_pkg::VAL_W'(-v) : mbe_pkg::VAL_W'(v);
  endfunction

  // Pick the operand halves for this partial product
  assign x_half  = step[1] ? xm[mbe_pkg::VAL_W-1:mbe_pkg::HALF_VW] : xm[mbe_pkg::HALF_VW-1:0];
  assign y_half  = step[0] ? ym[mbe_pkg::VAL_W-1:mbe_pkg::HALF_VW] : ym[mbe_pkg::HALF_VW-1:0];
  assign in_mult = busy && (step < mbe_pkg::MUL_STEP_W'(mbe_pkg::MUL_PARTS));
  assign in_acc  = busy && (step != '0) && (step <= mbe_pkg::MUL_STEP_W'(mbe_pkg::MUL_PARTS));
  assign last    = busy && (step == mbe_pkg::MUL_STEP_W'(mbe_pkg::MUL_PARTS + 1));

  // Shift the exact magnitude product down and clamp it
  always_comb begin
    shifted = dbl_q ? (acc >> (mbe_pkg::FRAC_W - 1)) : (acc >> mbe_pkg::FRAC_W);
    if (|shifted[mbe_pkg::PROD_W-1:mbe_pkg::VAL_W-1]) begin
      mag_res = mbe_pkg::SAT_MAX;
    end else begin
      mag_res = {1'b0, shifted[mbe_pkg::VAL_W-2:0]};
    end
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= last;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Operands, partial products and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      xm    <= mag(a);
      ym    <= mag(b);
      neg   <= a[mbe_pkg::VAL_W-1] ^ b[mbe_pkg::VAL_W-1];
      dbl_q <= dbl;
      acc   <= '0;
    end else begin
      if (in_mult) begin
        prod <= x_half * y_half;
        pw   <= {1'b0, step[1]} + {1'b0, step[0]};
      end
      if (in_acc) begin
        acc <= acc + ({{mbe_pkg::VAL_W{1'b0}}, prod} << {pw, 5'd0});
      end
      if (last) begin
        res <= neg ? -$signed(mag_res) : $signed(mag_res);
      end
    end
  end

endmodule
`default_nettype wire

[hdl/mbe_datapath.sv]
// Datapath: point mapping, complex iteration registers, bailout test, result.
`timescale 1ns / 1ps
`default_nettype none
module mbe_datapath (
  input  wire                               clk,
  input  wire                               rst,
  input  wire mbe_pkg::cfg_t                cfg,
  input  wire mbe_pkg::dp_cmd_t             cmd,
  output mbe_pkg::dp_status_t               st,
  input  wire logic [mbe_pkg::PIX_W-1:0]    pixel_x,
  input  wire logic [mbe_pkg::PIX_W-1:0]    pixel_y,
  output logic [mbe_pkg::ITER_W-1:0]        iter_value,
  output logic                              escaped
);

  logic [mbe_pkg::PIX_W-1:0]        px;
  logic [mbe_pkg::PIX_W-1:0]        py;
  logic signed [mbe_pkg::DX_W-1:0]  dx;
  logic signed [mbe_pkg::DX_W-1:0]  dy;
  logic signed [mbe_pkg::MAP_W-1:0] mx;
  logic signed [mbe_pkg::MAP_W-1:0] my;
  logic signed [mbe_pkg::VAL_W-1:0] cx;
  logic signed [mbe_pkg::VAL_W-1:0] cy;
  logic signed [mbe_pkg::VAL_W-1:0] zr;
  logic signed [mbe_pkg::VAL_W-1:0] zi;
  logic signed [mbe_pkg::VAL_W-1:0] sr;
  logic signed [mbe_pkg::VAL_W-1:0] si;
  logic signed [mbe_pkg::VAL_W-1:0] p;
  logic [mbe_pkg::ITER_W-1:0]       count;
  logic signed [mbe_pkg::VAL_W-1:0] res_sr;
  logic signed [mbe_pkg::VAL_W-1:0] res_si;
  logic signed [mbe_pkg::VAL_W-1:0] res_p;
  logic                             done_sr;
  logic                             done_si;
  logic                             done_p;
  logic signed [mbe_pkg::VAL_W-1:0] mag_sum;
  logic [mbe_pkg::BAIL_W-1:0]       bail_n;
  logic signed [mbe_pkg::VAL_W-1:0] bail;
  logic                             below_max;

  function automatic logic signed [mbe_pkg::VAL_W-1:0] sat_add(
    input logic signed [mbe_pkg::VAL_W-1:0] a,
    input logic signed [mbe_pkg::VAL_W-1:0] b
  );
    logic signed [mbe_pkg::VAL_W:0] s;
    s = (mbe_pkg::VAL_W+1)'(a) + (mbe_pkg::VAL_W+1)'(b);
    if (s > (mbe_pkg::VAL_W+1)'(mbe_pkg::SAT_MAX)) begin
      return mbe_pkg::SAT_MAX;
    end else if (s < (mbe_pkg::VAL_W+1)'(mbe_pkg::SAT_MIN)) begin
      return mbe_pkg::SAT_MIN;
    end
    return s[mbe_pkg::VAL_W-1:0];
  endfunction

  // Pixel offsets from the image center
  assign dx = $signed(mbe_pkg::DX_W'(px)) - $signed(mbe_pkg::DX_W'(mbe_pkg::HALF_W));
  assign dy = $signed(mbe_pkg::DX_W'(py)) - $signed(mbe_pkg::DX_W'(mbe_pkg::HALF_H));

  // Loop test: count below limit and |z|^2 below bailout
  assign bail_n    = mbe_pkg::BAIL_W'(cfg.max_iter) * mbe_pkg::BAIL_W'(mbe_pkg::BAIL_MUL);
  assign bail      = $signed(mbe_pkg::VAL_W'(bail_n) << mbe_pkg::FRAC_W);
  assign mag_sum   = sat_add(sr, si);
  assign below_max = count < cfg.max_iter;
  assign st.go       = below_max && (mag_sum < bail);
  assign st.mul_done = done_sr && done_si && done_p;

  // Square and cross-product units, run in lockstep
  mbe_mul u_mul_sr (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .dbl   (1'b0),
    .a     (zr),
    .b     (zr),
    .res   (res_sr),
    .done  (done_sr)
  );

  mbe_mul u_mul_si (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .dbl   (1'b0),
    .a     (zi),
    .b     (zi),
    .res   (res_si),
    .done  (done_si)
  );

  mbe_mul u_mul_p (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .dbl   (1'b1),
    .a     (zr),
    .b     (zi),
    .res   (res_p),
    .done  (done_p)
  );

  // Datapath registers, advanced by controller commands
  always_ff @(posedge clk) begin
    if (cmd.load_pix) begin
      px <= pixel_x;
      py <= pixel_y;
    end
    if (cmd.map) begin
      mx <= dx * $signed({1'b0, cfg.scale});
      my <= dy * $signed({1'b0, cfg.scale});
    end
    if (cmd.init) begin
      cx    <= mbe_pkg::VAL_W'(mx) + mbe_pkg::VAL_W'(cfg.offset_re);
      cy    <= mbe_pkg::VAL_W'(my) + mbe_pkg::VAL_W'(cfg.offset_im);
      zr    <= '0;
      zi    <= '0;
      sr    <= '0;
      si    <= '0;
      p     <= '0;
      count <= '0;
    end
    if (cmd.update) begin
      zr    <= sat_add(cx, sr - si);
      zi    <= sat_add(cy, p);
      count <= count + 1'b1;
    end
    if (st.mul_done) begin
      sr <= res_sr;
      si <= res_si;
      p  <= res_p;
    end
    if (cmd.load_out) begin
      escaped <= below_max;
      if (cfg.result_mode) begin
        iter_value <= below_max ? '0 : cfg.max_iter;
      end else begin
        iter_value <= count;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/mbe_ctrl.sv]
// Controller: sequences mapping, iterations and result handoff.
`timescale 1ns / 1ps
`default_nettype none
module mbe_ctrl (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       s_tvalid,
  output logic                      s_tready,
  output logic                      m_tvalid,
  input  wire                       m_tready,
  input  wire mbe_pkg::dp_status_t  st,
  output mbe_pkg::dp_cmd_t          cmd
);

  typedef enum logic [2:0] {
    IDLE,
    MAP,
    INIT,
    CHECK,
    UPDATE,
    MSTART,
    MWAIT,
    FINISH
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == IDLE);

  // Decode commands from state
  always_comb begin
    cmd = '0;
    case (state)
      IDLE:    cmd.load_pix  = s_tvalid;
      MAP:     cmd.map       = 1'b1;
      INIT:    cmd.init      = 1'b1;
      UPDATE:  cmd.update    = 1'b1;
      MSTART:  cmd.mul_start = 1'b1;
      FINISH:  cmd.load_out  = out_free;
      default: cmd = '0;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            state <= MAP;
          end
        end
        MAP:    state <= INIT;
        INIT:   state <= CHECK;
        CHECK:  state <= st.go ? UPDATE : FINISH;
        UPDATE: state <= MSTART;
        MSTART: state <= MWAIT;
        MWAIT: begin
          if (st.mul_done) begin
            state <= CHECK;
          end
        end
        FINISH: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/mandelbrot_escape_time.sv]
// Top level: stream ports, configuration registers, controller and datapath.
//
// Escape-time evaluator. Each input transaction on the s_ side carries one
// pixel; the pixel is mapped to c = (pixel - size/2) * scale + offset and
// z = z^2 + c is iterated in signed Q24.40 until the count reaches max_iter
// or |z|^2 reaches 50 * max_iter. One output transaction follows per pixel:
// the count (or the inside value in mode 1) in m_tdata, the escape flag in
// m_tuser.
// Sequencing: each iteration waits on the three sequential 64x64
// multipliers (four 32x32 partial products each plus finalize). One
// pixel is in flight at a time, and the next pixel can be taken in the
// cycle after the previous result is registered.
// The result sits in an output register, so a new pixel is accepted and
// computed while the receiver stalls; it then waits for the register.
// Configuration: writes on cfg_* take effect at once; cfg_ready is always
// high. Write only while no pixel is pending. Reset (rst, synchronous)
// restores register defaults and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none
module mandelbrot_escape_time (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   s_tvalid,
  output logic                                  s_tready,
  input  wire logic [mbe_pkg::IN_DATA_W-1:0]    s_tdata,   // pixel_x, pixel_y, zero pad
  output logic                                  m_tvalid,
  input  wire                                   m_tready,
  output logic [mbe_pkg::ITER_W-1:0]            m_tdata,   // iter_value
  output logic                                  m_tuser,   // escaped
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [mbe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mbe_pkg::CFG_W-1:0]        cfg_data
);

  mbe_pkg::cfg_t       cfg;
  mbe_pkg::dp_cmd_t    cmd;
  mbe_pkg::dp_status_t st;

  assign cfg_ready = 1'b1;

  // Configuration registers; drop writes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_iter    <= mbe_pkg::MAX_ITER_RST;
      cfg.scale       <= mbe_pkg::SCALE_RST;
      cfg.offset_re   <= '0;
      cfg.offset_im   <= '0;
      cfg.result_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mbe_pkg::REG_MAX_ITER:    cfg.max_iter    <= cfg_data[mbe_pkg::ITER_W-1:0];
        mbe_pkg::REG_SCALE:       cfg.scale       <= cfg_data;
        mbe_pkg::REG_OFFSET_RE:   cfg.offset_re   <= $signed(cfg_data);
        mbe_pkg::REG_OFFSET_IM:   cfg.offset_im   <= $signed(cfg_data);
        mbe_pkg::REG_RESULT_MODE: cfg.result_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .st       (st),
    .cmd      (cmd)
  );

  mbe_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .st         (st),
    .pixel_x    (s_tdata[mbe_pkg::PIX_W-1:0]),
    .pixel_y    (s_tdata[2*mbe_pkg::PIX_W-1:mbe_pkg::PIX_W]),
    .iter_value (m_tdata),
    .escaped    (m_tuser)
  );

  // One pixel at a time: input closes right after a transaction
  a_single_pixel: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted again while a pixel is in flight");

  // A result cannot appear right after a pixel is taken
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !$rose(m_tvalid))
    else $error("result raised directly after input transaction");

  // Multiplier completion only while a pixel is being worked on
  a_mul_busy: assert property (@(posedge clk) disable iff (rst)
    st.mul_done |-> !s_tready)
    else $error("multiplier completed while controller idle");

  // A new result is only raised from the finishing step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result raised from idle");

endmodule
`default_nettype wire

[sim/mandelbrot_escape_time_tb.sv]
// Self-checking stream testbench for the escape-time pixel evaluator.
`timescale 1ns / 1ps
module mandelbrot_escape_time_tb;

  localparam int unsigned ITER_CAP    = 300;          // longest pixel, in iterations, that queue_pixel allows
  localparam int unsigned NO_CAP      = 32'hFFFF_FFFF;
  localparam int          RAND_PHASES = 8;
  localparam int          PHASE_ITEMS = 172;
  localparam longint      CYCLE_LIMIT = 20_000_000;
  localparam longint      VAL_LIMIT   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int          MAX_REPORTS = 10;

  typedef struct {
    logic [mbe_pkg::PIX_W-1:0] x;
    logic [mbe_pkg::PIX_W-1:0] y;
  } pixel_t;

  typedef struct {
    pixel_t                     pix;
    logic [mbe_pkg::ITER_W-1:0] iter_value;
    logic                       escaped;
  } escape_result_t;

  logic                          clk;
  logic                          rst       = 1'b1;
  logic                          s_tvalid  = 1'b0;
  logic                          s_tready;
  logic [mbe_pkg::IN_DATA_W-1:0] s_tdata   = '0;  // pixel_x, pixel_y, zero pad
  logic                          m_tvalid;
  logic                          m_tready  = 1'b0;
  logic [mbe_pkg::ITER_W-1:0]    m_tdata;         // iter_value
  logic                          m_tuser;         // escaped
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [mbe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mbe_pkg::CFG_W-1:0]     cfg_data  = '0;

  mbe_pkg::cfg_t  view_cfg;
  pixel_t         pixels_to_send[$];
  escape_result_t results_due[$];
  int             pixels_queued  = 0;
  int             pixels_taken   = 0;
  int             mismatches     = 0;
  int             send_idle_pct  = 0;
  int             recv_stall_pct = 0;
  logic           pix_fire       = 1'b0;
  longint         cycle_count    = 0;

  mandelbrot_escape_time u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Saturating add, clamped to the symmetric Q24.40 range
  function automatic longint clamp_add(longint a, longint b);
    logic signed [64:0] sum;
    sum = 65'(a) + 65'(b);
    if (b > 0 && sum > VAL_LIMIT) return VAL_LIMIT;
    if (b < 0 && sum < -VAL_LIMIT) return -VAL_LIMIT;
    return sum[63:0];
  endfunction

  // Exact product, shifted down toward zero, then saturated
  function automatic longint mul_trunc_sat(longint a, longint b, int unsigned sh);
    logic [63:0]  mag_a, mag_b, mag_q;
    logic [127:0] prod;
    mag_a = (a < 0) ? 64'(-a) : 64'(a);
    mag_b = (b < 0) ? 64'(-b) : 64'(b);
    prod  = {64'b0, mag_a} * {64'b0, mag_b};
    prod  = prod >> sh;
    mag_q = (prod > 128'(VAL_LIMIT)) ? 64'(VAL_LIMIT) : prod[63:0];
    return ((a < 0) != (b < 0)) ? -longint'(mag_q) : longint'(mag_q);
  endfunction

  // Map the pixel, iterate z = z^2 + c; give up (return 0) past cap iterations
  function automatic bit escape_time(input mbe_pkg::cfg_t c, input pixel_t p,
                                     input int unsigned cap, output escape_result_t r);
    longint      cx, cy, bail, zr, zi, sr, si, next_zi;
    int unsigned count;
    bit          esc;
    cx = (longint'(p.x) - mbe_pkg::HALF_W) * longint'({20'b0, c.scale})
         + longint'($signed(c.offset_re));
    cy = (longint'(p.y) - mbe_pkg::HALF_H) * longint'({20'b0, c.scale})
         + longint'($signed(c.offset_im));
    bail = (longint'({48'b0, c.max_iter}) * mbe_pkg::BAIL_MUL) <<< mbe_pkg::FRAC_W;
    zr = 0;
    zi = 0;
    sr = 0;
    si = 0;
    count = 0;
    while (count < c.max_iter && clamp_add(sr, si) < bail) begin
      if (count >= cap) return 1'b0;
      next_zi = clamp_add(cy, mul_trunc_sat(zr, zi, mbe_pkg::FRAC_W - 1));
      zr = clamp_add(cx, sr - si);
      zi = next_zi;
      sr = mul_trunc_sat(zr, zr, mbe_pkg::FRAC_W);
      si = mul_trunc_sat(zi, zi, mbe_pkg::FRAC_W);
      count++;
    end
    esc = count < c.max_iter;
    r.pix = p;
    r.escaped = esc;
    r.iter_value = c.result_mode ? (esc ? '0 : c.max_iter) : count[mbe_pkg::ITER_W-1:0];
    return 1'b1;
  endfunction

  function automatic pixel_t at_pixel(int x, int y);
    at_pixel.x = mbe_pkg::PIX_W'(x);
    at_pixel.y = mbe_pkg::PIX_W'(y);
  endfunction

  // Queue a pixel unless it would run longer than the cap allows
  function automatic bit queue_pixel(pixel_t p);
    escape_result_t probe;
    if (!escape_time(view_cfg, p, ITER_CAP, probe)) return 1'b0;
    pixels_to_send.push_back(p);
    pixels_queued++;
    return 1'b1;
  endfunction

  function automatic void set_idling(int phase);
    case (phase % 4)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 46;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 46;
      end
      default: begin
        send_idle_pct = 38;
        recv_stall_pct = 38;
      end
    endcase
  endfunction

  function automatic logic [mbe_pkg::CFG_W-1:0] random_offset();
    logic [63:0] rv;
    rv = {$urandom, $urandom};
    if ($urandom_range(5, 0) == 0) return rv[mbe_pkg::CFG_W-1:0];
    return mbe_pkg::CFG_W'(longint'(rv[41:0]) - (longint'(1) <<< 41));
  endfunction

  // One register write transaction; the local copy follows at the handshake
  task automatic program_reg(input logic [mbe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mbe_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      mbe_pkg::REG_MAX_ITER:    view_cfg.max_iter    = value[mbe_pkg::ITER_W-1:0];
      mbe_pkg::REG_SCALE:       view_cfg.scale       = value;
      mbe_pkg::REG_OFFSET_RE:   view_cfg.offset_re   = value;
      mbe_pkg::REG_OFFSET_IM:   view_cfg.offset_im   = value;
      mbe_pkg::REG_RESULT_MODE: view_cfg.result_mode = value[0];
      default: ;
    endcase
  endtask

  task automatic finish_programming;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_for_results;
    @(negedge clk);
    while (pixels_taken != pixels_queued || results_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Pick a view: mostly short limits around the set, now and then a deep limit
  task automatic randomize_view;
    logic [63:0]                rv;
    logic [mbe_pkg::CFG_W-1:0]  sc;
    logic [mbe_pkg::ITER_W-1:0] limit;
    bit                         deep;
    deep = 1'b0;
    case ($urandom_range(9, 0))
      0: limit = 16'd1;
      7, 8: limit = mbe_pkg::ITER_W'($urandom_range(255, 65));
      9: begin
        limit = mbe_pkg::ITER_W'($urandom_range(65535, 1000));
        deep = 1'b1;
      end
      default: limit = mbe_pkg::ITER_W'($urandom_range(64, 2));
    endcase
    rv = {$urandom, $urandom};
    if (deep) begin
      sc = rv[mbe_pkg::CFG_W-1:0] | (44'd1 << 41);
    end else begin
      case ($urandom_range(7, 0))
        0: sc = rv[mbe_pkg::CFG_W-1:0];
        1: sc = mbe_pkg::CFG_W'($urandom_range(15, 0));
        default: sc = mbe_pkg::CFG_W'({$urandom | 32'h4000_0000}) << $urandom_range(2, 0);
      endcase
    end
    program_reg(mbe_pkg::REG_MAX_ITER, mbe_pkg::CFG_W'(limit));
    program_reg(mbe_pkg::REG_SCALE, sc);
    program_reg(mbe_pkg::REG_OFFSET_RE, random_offset());
    program_reg(mbe_pkg::REG_OFFSET_IM, random_offset());
    program_reg(mbe_pkg::REG_RESULT_MODE, mbe_pkg::CFG_W'($urandom_range(1, 0)));
  endtask

  // Drive pixels and output back-pressure on the falling edge
  always @(negedge clk) begin : driver
    pixel_t next_pix;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || pix_fire) begin
      if (pixels_to_send.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        next_pix = pixels_to_send.pop_front();
        s_tdata  <= {{(mbe_pkg::IN_DATA_W - 2 * mbe_pkg::PIX_W){1'b0}}, next_pix.y, next_pix.x};
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // Predict on each pixel transaction, check each result transaction
  always @(posedge clk) begin : monitor
    escape_result_t want;
    pixel_t         seen;
    pix_fire <= s_tvalid && s_tready && !rst;
    if (!rst && s_tvalid && s_tready) begin
      seen.x = s_tdata[mbe_pkg::PIX_W-1:0];
      seen.y = s_tdata[2*mbe_pkg::PIX_W-1:mbe_pkg::PIX_W];
      void'(escape_time(view_cfg, seen, NO_CAP, want));
      results_due.push_back(want);
      pixels_taken++;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (results_due.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected result transaction: iter_value %0d escaped %0b", m_tdata, m_tuser);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (m_tdata !== want.iter_value || m_tuser !== want.escaped) begin
          if (mismatches < MAX_REPORTS)
            $display("pixel (%0d,%0d): expected iter_value %0d escaped %0b, got %0d %0b",
                     want.pix.x, want.pix.y, want.iter_value, want.escaped, m_tdata, m_tuser);
          mismatches++;
        end
      end
    end
  end

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    pixel_t p;
    int     placed;
    int     tries;
    view_cfg.max_iter    = mbe_pkg::MAX_ITER_RST;
    view_cfg.scale       = mbe_pkg::SCALE_RST;
    view_cfg.offset_re   = '0;
    view_cfg.offset_im   = '0;
    view_cfg.result_mode = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset view: corners, the center, points on the real axis inside the set and one off-axis point
    set_idling(0);
    void'(queue_pixel(at_pixel(0, 0)));
    void'(queue_pixel(at_pixel(1023, 1023)));
    void'(queue_pixel(at_pixel(0, 1023)));
    void'(queue_pixel(at_pixel(1023, 0)));
    void'(queue_pixel(at_pixel(mbe_pkg::HALF_W, mbe_pkg::HALF_H)));
    void'(queue_pixel(at_pixel(384, mbe_pkg::HALF_H)));
    void'(queue_pixel(at_pixel(256, mbe_pkg::HALF_H)));
    void'(queue_pixel(at_pixel(600, 700)));
    wait_for_results;

    // Zero iteration limit in both result modes
    program_reg(mbe_pkg::REG_MAX_ITER, '0);
    program_reg(mbe_pkg::REG_RESULT_MODE, '0);
    void'(queue_pixel(at_pixel(0, 0)));
    void'(queue_pixel(at_pixel(mbe_pkg::HALF_W, mbe_pkg::HALF_H)));
    finish_programming;
    wait_for_results;
    program_reg(mbe_pkg::REG_RESULT_MODE, 44'd1);
    void'(queue_pixel(at_pixel(1023, 1023)));
    finish_programming;
    wait_for_results;

    // Widest limit and scale, offsets at +4.0 and -4.0: corners saturate and escape
    set_idling(1);
    program_reg(mbe_pkg::REG_MAX_ITER, 44'hFFFF);
    program_reg(mbe_pkg::REG_SCALE, {mbe_pkg::CFG_W{1'b1}});
    program_reg(mbe_pkg::REG_OFFSET_RE, 44'h400_0000_0000);
    program_reg(mbe_pkg::REG_OFFSET_IM, 44'hC00_0000_0000);
    void'(queue_pixel(at_pixel(0, 0)));
    void'(queue_pixel(at_pixel(1023, 1023)));
    void'(queue_pixel(at_pixel(0, 1023)));
    void'(queue_pixel(at_pixel(1023, 0)));
    finish_programming;
    wait_for_results;
    program_reg(mbe_pkg::REG_RESULT_MODE, '0);
    void'(queue_pixel(at_pixel(0, 0)));
    void'(queue_pixel(at_pixel(1023, 1023)));
    void'(queue_pixel(at_pixel(0, 1023)));
    void'(queue_pixel(at_pixel(1023, 0)));
    finish_programming;
    wait_for_results;

    // Zero scale: every pixel lands on c = -1, a period-two orbit
    set_idling(2);
    program_reg(mbe_pkg::REG_SCALE, '0);
    program_reg(mbe_pkg::REG_MAX_ITER, 44'd40);
    program_reg(mbe_pkg::REG_OFFSET_RE, 44'hF00_0000_0000);
    program_reg(mbe_pkg::REG_OFFSET_IM, '0);
    void'(queue_pixel(at_pixel(3, 700)));
    void'(queue_pixel(at_pixel(1023, 0)));
    finish_programming;
    wait_for_results;

    // Limit of one with the offset far out: the single pass ends at the limit without escape
    program_reg(mbe_pkg::REG_MAX_ITER, 44'd1);
    program_reg(mbe_pkg::REG_OFFSET_RE, 44'h800_0000_0000);
    program_reg(mbe_pkg::REG_OFFSET_IM, 44'h7FF_FFFF_FFFF);
    void'(queue_pixel(at_pixel(mbe_pkg::HALF_W, mbe_pkg::HALF_H)));
    void'(queue_pixel(at_pixel(1, 2)));
    finish_programming;
    wait_for_results;

    // Indexes past the register list must leave the settings alone
    set_idling(3);
    program_reg(mbe_pkg::REG_MAX_ITER, 44'd30);
    program_reg(mbe_pkg::REG_SCALE, mbe_pkg::SCALE_RST);
    for (int i = int'(mbe_pkg::REG_RESULT_MODE) + 1; i < (1 << mbe_pkg::CFG_IDX_W); i++)
      program_reg(mbe_pkg::CFG_IDX_W'(i), mbe_pkg::CFG_W'({$urandom, $urandom}));
    void'(queue_pixel(at_pixel(0, 0)));
    void'(queue_pixel(at_pixel(700, 300)));
    finish_programming;
    wait_for_results;

    // Random views, one idling pattern per phase
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      set_idling(ph);
      randomize_view;
      placed = 0;
      for (tries = 0; placed < PHASE_ITEMS && tries < 3 * PHASE_ITEMS; tries++) begin
        p.x = mbe_pkg::PIX_W'($urandom);
        p.y = mbe_pkg::PIX_W'($urandom);
        placed += int'(queue_pixel(p));
      end
      finish_programming;
      wait_for_results;
    end

    repeat (50) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[mandelbrot_escape_time.f]
hdl/mbe_pkg.sv
hdl/mbe_mul.sv
hdl/mbe_datapath.sv
hdl/mbe_ctrl.sv
hdl/mandelbrot_escape_time.sv
sim/mandelbrot_escape_time_tb.sv
